// ===== rtl/core/mhrb_pkg.sv =====
package mhrb_pkg;

    // Register byte offsets
    localparam logic [6:0] OFF_STRPCL    = 7'h00;
    localparam logic [6:0] OFF_STAT      = 7'h04;
    localparam logic [6:0] OFF_CLKRT     = 7'h08;
    localparam logic [6:0] OFF_SPI       = 7'h0C;
    localparam logic [6:0] OFF_CMDAT     = 7'h10;
    localparam logic [6:0] OFF_RESTO     = 7'h14;
    localparam logic [6:0] OFF_RDTO      = 7'h18;
    localparam logic [6:0] OFF_BLKLEN    = 7'h1C;
    localparam logic [6:0] OFF_NUMBLK    = 7'h20;
    localparam logic [6:0] OFF_I_MASK    = 7'h28;
    localparam logic [6:0] OFF_I_REG     = 7'h2C;
    localparam logic [6:0] OFF_CMD       = 7'h30;
    localparam logic [6:0] OFF_ARGH      = 7'h34;
    localparam logic [6:0] OFF_ARGL      = 7'h38;
    localparam logic [6:0] OFF_RDWAIT    = 7'h48;
    localparam logic [6:0] OFF_BLKS_LEFT = 7'h4C;
    localparam logic [6:0] OFF_END       = 7'h50;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [13:0] CMDAT_RW_MASK   = 14'h3DFF;
    localparam logic [13:0] CMDAT_RESET     = 14'h0080;
    localparam int          CMDAT_STOP_BIT  = 10;
    localparam logic [5:0]  CMD_NO_CLEAR    = 6'd52;
    localparam logic [15:0] CMD_TRANSMIT    = 16'h0040;
    localparam logic [13:0] ST_CMD_DONE     = 14'h2002; // end of response plus response timeout
    localparam logic [6:0]  RESTO_RESET     = 7'd64;
    localparam logic [12:0] IMASK_RESET     = 13'h1FFF;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_level;
        logic        access_fault;
    } mhrb_rsp_t;

endpackage

// ===== rtl/core/mhrb_regs.sv =====
module mhrb_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                op,
    input  logic [6:0]          byte_offset,
    input  logic [31:0]         write_data,
    output mhrb_pkg::mhrb_rsp_t rsp
);
    import mhrb_pkg::*;

    logic [13:0] status_reg,    status_next;
    logic        running_reg,   running_next;
    logic        pending_reg,   pending_next;
    logic        stopped_reg,   stopped_next;
    logic [2:0]  clkrt_reg,     clkrt_next;
    logic [3:0]  spi_reg,       spi_next;
    logic [13:0] cmdat_reg,     cmdat_next;
    logic [6:0]  resto_reg,     resto_next;
    logic [15:0] rdto_reg,      rdto_next;
    logic [11:0] blklen_reg,    blklen_next;
    logic [15:0] numblk_reg,    numblk_next;
    logic [12:0] imask_reg,     imask_next;
    logic [5:0]  cmd_reg,       cmd_next;
    logic [15:0] argh_reg,      argh_next;
    logic [15:0] argl_reg,      argl_next;
    logic        rdwait_reg,    rdwait_next;
    logic [15:0] blksrem_reg,   blksrem_next;

    logic        fault;
    logic [12:0] causes_cur;
    logic [12:0] causes_next;
    logic [15:0] rd_val;
    logic [13:0] cmdat_w;

    function automatic logic [12:0] int_causes(input logic [13:0] st, input logic stp);
        logic [12:0] v;
        v    = '0;
        v[0] = st[11];
        v[1] = st[12];
        v[2] = st[13];
        v[4] = stp;
        v[9] = st[5] | st[1];
        return v;
    endfunction

    assign fault      = (byte_offset >= OFF_END) || (byte_offset[1:0] != 2'b00);
    assign causes_cur = int_causes(status_reg, stopped_reg);
    assign cmdat_w    = write_data[13:0] & CMDAT_RW_MASK;

    // read mux
    always_comb begin
        unique case (byte_offset)
            OFF_STAT:      rd_val = {2'b00, status_reg | {5'b0, running_reg, 8'b0}};
            OFF_CLKRT:     rd_val = {13'b0, clkrt_reg};
            OFF_SPI:       rd_val = {12'b0, spi_reg};
            OFF_CMDAT:     rd_val = {2'b00, cmdat_reg};
            OFF_RESTO:     rd_val = {9'b0, resto_reg};
            OFF_RDTO:      rd_val = rdto_reg;
            OFF_BLKLEN:    rd_val = {4'b0, blklen_reg};
            OFF_NUMBLK:    rd_val = numblk_reg;
            OFF_I_MASK:    rd_val = {3'b0, imask_reg};
            OFF_I_REG:     rd_val = {3'b0, causes_cur};
            OFF_CMD:       rd_val = {10'b0, cmd_reg} | CMD_TRANSMIT;
            OFF_ARGH:      rd_val = argh_reg;
            OFF_ARGL:      rd_val = argl_reg;
            OFF_RDWAIT:    rd_val = {15'b0, rdwait_reg};
            OFF_BLKS_LEFT: rd_val = blksrem_reg;
            default:       rd_val = '0;
        endcase
    end

    // write decode and command sequencing
    always_comb begin
        status_next  = status_reg;
        running_next = running_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        clkrt_next   = clkrt_reg;
        spi_next     = spi_reg;
        cmdat_next   = cmdat_reg;
        resto_next   = resto_reg;
        rdto_next    = rdto_reg;
        blklen_next  = blklen_reg;
        numblk_next  = numblk_reg;
        imask_next   = imask_reg;
        cmd_next     = cmd_reg;
        argh_next    = argh_reg;
        argl_next    = argl_reg;
        rdwait_next  = rdwait_reg;
        blksrem_next = blksrem_reg;
        if (fire && !fault && op == OP_WRITE) begin
            unique case (byte_offset)
                OFF_STRPCL: begin
                    // start wins over stop
                    if (write_data[1]) begin
                        running_next = 1'b1;
                        stopped_next = 1'b0;
                    end else if (write_data[0]) begin
                        running_next = 1'b0;
                        stopped_next = 1'b1;
                    end
                    if (running_next && pending_reg) begin
                        pending_next = 1'b0;
                        status_next  = status_reg | ST_CMD_DONE;
                    end
                end
                OFF_CLKRT:     clkrt_next   = write_data[2:0];
                OFF_SPI:       spi_next     = write_data[3:0];
                OFF_CMDAT: begin
                    cmdat_next = cmdat_w;
                    if (!cmdat_w[CMDAT_STOP_BIT]) begin
                        // CMD52 keeps prior status
                        if (cmd_reg != CMD_NO_CLEAR) begin
                            status_next = '0;
                        end
                        if (running_reg) begin
                            pending_next = 1'b0;
                            status_next  = status_next | ST_CMD_DONE;
                        end else begin
                            pending_next = 1'b1;
                        end
                    end
                end
                OFF_RESTO:     resto_next   = write_data[6:0];
                OFF_RDTO:      rdto_next    = write_data[15:0];
                OFF_BLKLEN:    blklen_next  = write_data[11:0];
                OFF_NUMBLK:    numblk_next  = write_data[15:0];
                OFF_I_MASK:    imask_next   = write_data[12:0];
                OFF_CMD:       cmd_next     = write_data[5:0];
                OFF_ARGH:      argh_next    = write_data[15:0];
                OFF_ARGL:      argl_next    = write_data[15:0];
                OFF_RDWAIT:    rdwait_next  = write_data[0];
                OFF_BLKS_LEFT: blksrem_next = write_data[15:0];
                default: ;
            endcase
        end
    end

    assign causes_next = int_causes(status_next, stopped_next);

    always_comb begin
        rsp.read_data    = (!fault && op == OP_READ) ? rd_val : 16'h0000;
        rsp.irq_level    = |(causes_next & ~imask_next);
        rsp.access_fault = fault;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= '0;
            running_reg <= 1'b0;
            pending_reg <= 1'b0;
            stopped_reg <= 1'b0;
            clkrt_reg   <= '0;
            spi_reg     <= '0;
            cmdat_reg   <= CMDAT_RESET;
            resto_reg   <= RESTO_RESET;
            rdto_reg    <= '1;
            blklen_reg  <= '0;
            numblk_reg  <= '0;
            imask_reg   <= IMASK_RESET;
            cmd_reg     <= '0;
            argh_reg    <= '0;
            argl_reg    <= '0;
            rdwait_reg  <= 1'b0;
            blksrem_reg <= '0;
        end else begin
            status_reg  <= status_next;
            running_reg <= running_next;
            pending_reg <= pending_next;
            stopped_reg <= stopped_next;
            clkrt_reg   <= clkrt_next;
            spi_reg     <= spi_next;
            cmdat_reg   <= cmdat_next;
            resto_reg   <= resto_next;
            rdto_reg    <= rdto_next;
            blklen_reg  <= blklen_next;
            numblk_reg  <= numblk_next;
            imask_reg   <= imask_next;
            cmd_reg     <= cmd_next;
            argh_reg    <= argh_next;
            argl_reg    <= argl_next;
            rdwait_reg  <= rdwait_next;
            blksrem_reg <= blksrem_next;
        end
    end

    // a command never stays pending while the clock runs
    a_no_pending_when_running: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pending_reg && running_reg))
        else $error("command pending with clock running");

    a_run_stop_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(running_reg && stopped_reg))
        else $error("clock running and stopped flags both set");

    a_fault_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && fault) |=> ($stable(status_reg) && $stable(pending_reg)
                             && $stable(running_reg) && $stable(imask_reg)))
        else $error("faulting word changed state");

    a_write_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op == OP_WRITE) |-> (rsp.read_data == 16'h0000))
        else $error("write word returned read data");

endmodule

// ===== rtl/core/mmc_host_register_block_unit.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_op, s_byte_offset, s_write_data
// m_        out        m_valid / m_ready  m_read_data, m_irq_level, m_access_fault
//
// Each word is registered in the input stage, then decoded and applied to the
// register file as it moves into the result register. While m_ready does not
// stall, one word per cycle is sustained. Reset (aresetn low, synchronous)
// empties both stages and loads the register reset values. A stalled m_ready
// holds the result; the input stage still takes one more word, then s_ready
// drops until the result is taken.
module mmc_host_register_block_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [6:0]  s_byte_offset,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic        m_irq_level,
    output logic        m_access_fault
);
    import mhrb_pkg::*;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic        in_op_reg;
    logic [6:0]  in_off_reg;
    logic [31:0] in_data_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    mhrb_rsp_t   out_rsp_reg;

    logic        advance;
    logic        fire;
    logic        s_accept;
    mhrb_rsp_t   rsp;

    assign advance  = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && advance;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // register file: state changes only when a word moves to the result stage
    mhrb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .op          (in_op_reg),
        .byte_offset (in_off_reg),
        .write_data  (in_data_reg),
        .rsp         (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_op;
            in_off_reg  <= s_byte_offset;
            in_data_reg <= s_write_data;
        end
        if (fire) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_rsp_reg.read_data;
    assign m_irq_level    = out_rsp_reg.irq_level;
    assign m_access_fault = out_rsp_reg.access_fault;

endmodule
